// File: rtl/core/chunked_transfer_reassembler_top_defines.svh
`ifndef CHUNKED_TRANSFER_REASSEMBLER_TOP_DEFINES_SVH
`define CHUNKED_TRANSFER_REASSEMBLER_TOP_DEFINES_SVH

// same-cycle implication, checked on aclk outside reset
`define CTR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ctr check failed");

// next-cycle implication, checked on aclk outside reset
`define CTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ctr check failed");

`endif

// File: rtl/core/ctr_pkg.sv
`timescale 1ns / 1ps

package ctr_pkg;

    localparam int PAYLOAD_BYTES = 16;
    localparam int MAX_BYTES     = 1024;
    localparam int MAX_CHUNKS    = 64;

    localparam int OFF_W   = $clog2(PAYLOAD_BYTES);
    localparam int CHUNK_W = $clog2(MAX_CHUNKS);
    localparam int ADDR_W  = $clog2(MAX_BYTES);

    localparam logic [2:0] REQ_START  = 3'd0;
    localparam logic [2:0] REQ_CHUNK  = 3'd1;
    localparam logic [2:0] REQ_COMMIT = 3'd2;
    localparam logic [2:0] REQ_RESET  = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADCMD   = 3'd1;
    localparam logic [2:0] ST_BUSY     = 3'd2;
    localparam logic [2:0] ST_TOOBIG   = 3'd3;
    localparam logic [2:0] ST_BADCHUNK = 3'd4;
    localparam logic [2:0] ST_DUP      = 3'd5;
    localparam logic [2:0] ST_MISSING  = 3'd6;

    typedef enum logic [0:0] {
        CTR_IDLE   = 1'b0,
        CTR_RDWAIT = 1'b1
    } ctr_state_t;

    typedef struct packed {
        logic take;
        logic fin_read;
    } ctr_cmd_t;

    typedef struct packed {
        logic gives_result;
        logic is_read;
    } ctr_sts_t;

endpackage

// File: rtl/core/ctr_ctrl.sv
`timescale 1ns / 1ps
`include "chunked_transfer_reassembler_top_defines.svh"

module ctr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ctr_pkg::ctr_sts_t sts,
    output ctr_pkg::ctr_cmd_t cmd
);
    import ctr_pkg::*;

    ctr_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CTR_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CTR_IDLE: begin
                if (cmd.take && sts.is_read) begin
                    state_next = CTR_RDWAIT;
                end
            end
            CTR_RDWAIT: begin
                state_next = CTR_IDLE;
            end
            default: begin
                state_next = CTR_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        cmd.fin_read = 1'b0;
        case (state_reg)
            CTR_IDLE: begin
                s_ready = !out_valid_reg || m_ready;
            end
            CTR_RDWAIT: begin
                cmd.fin_read = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.take = s_valid && s_ready;
        m_valid  = out_valid_reg;
        load     = (cmd.take && sts.gives_result && !sts.is_read) || cmd.fin_read;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    `CTR_ASSERT_NEXT(a_rdwait_one_cycle, state_reg == CTR_RDWAIT, state_reg == CTR_IDLE)
    `CTR_ASSERT_NEXT(a_read_enters_wait, cmd.take && sts.is_read, state_reg == CTR_RDWAIT)
    `CTR_ASSERT_NOW(a_no_take_when_full, out_valid_reg && !m_ready, !cmd.take)
    `CTR_ASSERT_NEXT(a_read_result_shown, cmd.fin_read, out_valid_reg)

endmodule

// File: rtl/core/ctr_datapath.sv
`timescale 1ns / 1ps

module ctr_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  ctr_pkg::ctr_cmd_t cmd,
    output ctr_pkg::ctr_sts_t sts,
    input  logic [2:0]        s_req_type,
    input  logic [15:0]       s_task_id,
    input  logic [15:0]       s_byte_count,
    input  logic [15:0]       s_chunk_count,
    input  logic [15:0]       s_chunk_num,
    input  logic [4:0]        s_data_len,
    input  logic [7:0]        s_payload_byte,
    input  logic              s_chunk_last,
    input  logic [9:0]        s_read_addr,
    output logic [2:0]        m_status,
    output logic [10:0]       m_length,
    output logic [7:0]        m_read_byte
);
    import ctr_pkg::*;

    logic                  active_reg, active_next;
    logic [15:0]           cur_task_reg, cur_task_next;
    logic [10:0]           exp_bytes_reg, exp_bytes_next;
    logic [6:0]            exp_chunks_reg, exp_chunks_next;
    logic [6:0]            chunks_rcv_reg, chunks_rcv_next;
    logic [10:0]           bytes_rcv_reg, bytes_rcv_next;
    logic [MAX_CHUNKS-1:0] seen_reg, seen_next;
    logic [4:0]            bic_reg, bic_next;
    logic                  hok_reg, hok_next;

    logic [7:0]            store [MAX_BYTES];
    logic [7:0]            rd_q_reg;
    logic [2:0]            pend_status_reg;
    logic [2:0]            status_reg;
    logic [10:0]           length_reg;
    logic [7:0]            read_byte_reg;

    logic [CHUNK_W-1:0]    idx_lo;
    logic [10:0]           off;
    logic [10:0]           remain;
    logic [4:0]            want;
    logic [2:0]            now;
    logic                  hok_eff;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [4:0]            bic_inc;
    logic [4:0]            need_items;
    logic [16:0]           round_sum;
    logic [15:0]           need_chunks;
    logic                  complete;
    logic [2:0]            res_status;
    logic [10:0]           res_length;

    assign sts.is_read      = (s_req_type == REQ_READ);
    assign sts.gives_result = !((s_req_type == REQ_CHUNK) && !s_chunk_last);

    assign idx_lo  = s_chunk_num[CHUNK_W-1:0];
    assign off     = 11'({idx_lo, {OFF_W{1'b0}}});
    assign remain  = exp_bytes_reg - off;
    assign wr_addr = ADDR_W'({idx_lo, bic_reg[OFF_W-1:0]});

    always_comb begin
        if (exp_bytes_reg == 11'd0) begin
            want = 5'd0;
        end else if (remain > 11'(PAYLOAD_BYTES)) begin
            want = 5'(PAYLOAD_BYTES);
        end else begin
            want = remain[4:0];
        end
        if (!active_reg) begin
            now = ST_BADCHUNK;
        end else if (s_task_id != cur_task_reg || s_chunk_count != 16'(exp_chunks_reg)) begin
            now = ST_BADCHUNK;
        end else if (s_chunk_num >= 16'(exp_chunks_reg)
                     || s_chunk_num >= 16'(MAX_CHUNKS)) begin
            now = ST_BADCHUNK;
        end else if (seen_reg[idx_lo]) begin
            now = ST_DUP;
        end else if (off > exp_bytes_reg) begin
            now = ST_BADCHUNK;
        end else if (s_data_len != want) begin
            now = ST_BADCHUNK;
        end else begin
            now = ST_OK;
        end
    end

    always_comb begin
        hok_eff     = (bic_reg == 5'd0) ? (now == ST_OK) : hok_reg;
        wr_en       = cmd.take && (s_req_type == REQ_CHUNK) && hok_eff && (now == ST_OK)
                      && (s_data_len != 5'd0) && (bic_reg < s_data_len);
        bic_inc     = (bic_reg == 5'd31) ? 5'd31 : bic_reg + 5'd1;
        need_items  = (s_data_len == 5'd0) ? 5'd1 : s_data_len;
        round_sum   = {1'b0, s_byte_count} + 17'(PAYLOAD_BYTES - 1);
        need_chunks = (s_byte_count == 16'd0) ? 16'd1 : 16'(round_sum >> OFF_W);
        complete    = (chunks_rcv_reg == exp_chunks_reg) && (bytes_rcv_reg == exp_bytes_reg);

        active_next     = active_reg;
        cur_task_next   = cur_task_reg;
        exp_bytes_next  = exp_bytes_reg;
        exp_chunks_next = exp_chunks_reg;
        chunks_rcv_next = chunks_rcv_reg;
        bytes_rcv_next  = bytes_rcv_reg;
        seen_next       = seen_reg;
        bic_next        = bic_reg;
        hok_next        = hok_reg;
        res_status      = ST_OK;
        res_length      = 11'd0;

        if (cmd.take) begin
            bic_next = 5'd0;
            hok_next = 1'b0;
            case (s_req_type)
                REQ_CHUNK: begin
                    if (s_chunk_last) begin
                        res_status = now;
                        if (now == ST_OK) begin
                            if (!hok_eff || bic_inc != need_items) begin
                                res_status = ST_BADCHUNK;
                            end else begin
                                seen_next[idx_lo] = 1'b1;
                                chunks_rcv_next   = chunks_rcv_reg + 7'd1;
                                bytes_rcv_next    = bytes_rcv_reg + 11'(s_data_len);
                            end
                        end
                    end else begin
                        bic_next = bic_inc;
                        hok_next = hok_eff;
                    end
                end
                REQ_START: begin
                    if (active_reg) begin
                        res_status = ST_BUSY;
                    end else if (s_byte_count > 16'(MAX_BYTES)) begin
                        res_status = ST_TOOBIG;
                    end else if (s_chunk_count == 16'd0 || s_chunk_count != need_chunks) begin
                        res_status = ST_BADCMD;
                    end else if (s_chunk_count > 16'(MAX_CHUNKS)) begin
                        res_status = ST_TOOBIG;
                    end else begin
                        active_next     = 1'b1;
                        cur_task_next   = s_task_id;
                        exp_bytes_next  = s_byte_count[10:0];
                        exp_chunks_next = s_chunk_count[6:0];
                        chunks_rcv_next = 7'd0;
                        bytes_rcv_next  = 11'd0;
                        seen_next       = '0;
                    end
                end
                REQ_COMMIT: begin
                    if (!active_reg || s_task_id != cur_task_reg
                        || s_byte_count != 16'(exp_bytes_reg)
                        || s_chunk_count != 16'(exp_chunks_reg)) begin
                        res_status = ST_BADCMD;
                    end else if (!complete) begin
                        res_status = ST_MISSING;
                    end else begin
                        res_length = exp_bytes_reg;
                    end
                end
                REQ_RESET: begin
                    active_next     = 1'b0;
                    cur_task_next   = 16'd0;
                    exp_bytes_next  = 11'd0;
                    exp_chunks_next = 7'd0;
                    chunks_rcv_next = 7'd0;
                    bytes_rcv_next  = 11'd0;
                    seen_next       = '0;
                end
                REQ_READ: begin
                    if (!active_reg || 11'(s_read_addr) >= exp_bytes_reg) begin
                        res_status = ST_BADCMD;
                    end else if (!complete) begin
                        res_status = ST_MISSING;
                    end else begin
                        res_status = ST_OK;
                    end
                end
                default: begin
                    res_status = ST_BADCMD;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            cur_task_reg   <= 16'd0;
            exp_bytes_reg  <= 11'd0;
            exp_chunks_reg <= 7'd0;
            chunks_rcv_reg <= 7'd0;
            bytes_rcv_reg  <= 11'd0;
            seen_reg       <= '0;
            bic_reg        <= 5'd0;
            hok_reg        <= 1'b0;
        end else begin
            active_reg     <= active_next;
            cur_task_reg   <= cur_task_next;
            exp_bytes_reg  <= exp_bytes_next;
            exp_chunks_reg <= exp_chunks_next;
            chunks_rcv_reg <= chunks_rcv_next;
            bytes_rcv_reg  <= bytes_rcv_next;
            seen_reg       <= seen_next;
            bic_reg        <= bic_next;
            hok_reg        <= hok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= s_payload_byte;
        end
        if (cmd.take && sts.is_read) begin
            rd_q_reg        <= store[s_read_addr];
            pend_status_reg <= res_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_read) begin
            status_reg    <= pend_status_reg;
            length_reg    <= 11'd0;
            read_byte_reg <= (pend_status_reg == ST_OK) ? rd_q_reg : 8'd0;
        end else if (cmd.take && sts.gives_result && !sts.is_read) begin
            status_reg    <= res_status;
            length_reg    <= res_length;
            read_byte_reg <= 8'd0;
        end
    end

    assign m_status    = status_reg;
    assign m_length    = length_reg;
    assign m_read_byte = read_byte_reg;

endmodule

// File: rtl/core/chunked_transfer_reassembler_top.sv
`timescale 1ns / 1ps

// Chunked transfer reassembler: start, chunk-byte, commit, reset and read requests enter on
// the s_ channel; each request except a chunk byte without s_chunk_last returns one result on
// the m_ channel, held in an output register until taken. A read registers the byte from the
// 1024-byte store's read port first, taking no request meanwhile. Chunk-seen flags and all task
// counters clear at once on reset, so the block needs no clearing pass. Outside a read wait, a new
// request is taken while the previous result is being taken in the same cycle.
module chunked_transfer_reassembler_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [15:0] s_task_id,
    input  logic [15:0] s_byte_count,
    input  logic [15:0] s_chunk_count,
    input  logic [15:0] s_chunk_num,
    input  logic [4:0]  s_data_len,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_chunk_last,
    input  logic [9:0]  s_read_addr,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [10:0] m_length,
    output logic [7:0]  m_read_byte
);
    import ctr_pkg::*;

    ctr_cmd_t cmd;
    ctr_sts_t sts;

    ctr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    ctr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_req_type     (s_req_type),
        .s_task_id      (s_task_id),
        .s_byte_count   (s_byte_count),
        .s_chunk_count  (s_chunk_count),
        .s_chunk_num    (s_chunk_num),
        .s_data_len     (s_data_len),
        .s_payload_byte (s_payload_byte),
        .s_chunk_last   (s_chunk_last),
        .s_read_addr    (s_read_addr),
        .m_status       (m_status),
        .m_length       (m_length),
        .m_read_byte    (m_read_byte)
    );

endmodule
